FILE: src/bte_pkg.sv
package bte_pkg;

    localparam int unsigned WORD_W = 32;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] amp_tangent1;
        logic signed [31:0] amp_tangent2;
        logic signed [31:0] amp_normal;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] time_now;
        logic signed [31:0] start_time;
        logic signed [31:0] history_value;
        logic               last_term;
    } bte_in_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               saturated;
    } bte_out_t;

    typedef enum logic [1:0] {
        CMD_INITIAL = 2'd0,
        CMD_RATE    = 2'd1,
        CMD_HISTORY = 2'd2,
        CMD_NONE    = 2'd3
    } bte_cmd_t;

    typedef enum logic [2:0] {
        REG_DIM    = 3'd0,
        REG_REF1_X = 3'd1,
        REG_REF1_Y = 3'd2,
        REG_REF1_Z = 3'd3,
        REG_REF2_X = 3'd4,
        REG_REF2_Y = 3'd5,
        REG_REF2_Z = 3'd6
    } bte_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } bte_state_t;

    // one micro-op of the shared multiply-accumulate unit
    typedef struct packed {
        logic       start;   // clear accumulator before adding
        logic       negate;  // subtract the product
        logic       raw;     // add the shifted product without saturating it
    } bte_mac_ctl_t;

endpackage

FILE: src/bte_mac.sv
// Shared multiplier: floor-shifted product, saturated unless raw, added into a wide accumulator.
module bte_mac #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  bte_pkg::bte_mac_ctl_t ctl,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    output logic signed [63:0]  acc,
    output logic                psat
);
    import bte_pkg::*;

    localparam logic signed [63:0] MAXV = 64'sd2147483647;
    localparam logic signed [63:0] MINV = -64'sd2147483648;

    logic signed [63:0] prod;
    logic signed [63:0] shifted;
    logic signed [31:0] prod_sat;
    logic signed [63:0] addend;
    logic signed [63:0] base;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;

    always_comb
    begin
        prod    = 64'(a) * 64'(b);
        shifted = prod >>> FRACTION_BITS;
        psat    = 1'b0;
        if (shifted > MAXV)
        begin
            prod_sat = 32'sh7fffffff;
            psat     = 1'b1;
        end
        else if (shifted < MINV)
        begin
            prod_sat = 32'sh80000000;
            psat     = 1'b1;
        end
        else
        begin
            prod_sat = shifted[31:0];
        end
        addend = ctl.raw ? shifted : 64'(prod_sat);
        base   = ctl.start ? 64'sd0 : acc_reg;
        if (ctl.negate)
            acc_next = base - addend;
        else
            acc_next = base + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (en)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;
endmodule

FILE: src/boundary_traction_evaluator.sv
// channel | valid    | stall    | payload
// --------+----------+----------+---------------------
// in      | in_valid | in_stall | in_data  (bte_in_t)
// out     | out_valid| out_stall| out_data (bte_out_t)
// cfg     | cfg_we   | -        | cfg_index, cfg_data
// One term in 3-D takes 27 multiplies on the shared multiplier, a final step to fold in
// the last product, result write and idle; in 2-D it takes 6 multiplies; command 3 skips them.
// The shared multiplier sets the pace.
// Reset clears the sums, flag and registers to their reset values.
// A held result stalls the input until it is taken.
module boundary_traction_evaluator #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bte_pkg::bte_in_t   in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bte_pkg::bte_out_t  out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import bte_pkg::*;

    localparam logic signed [63:0] THR = (64'sd98 <<< FRACTION_BITS) / 64'sd100;
    localparam logic signed [35:0] MAX36 = 36'sd2147483647;
    localparam logic signed [35:0] MIN36 = -36'sd2147483648;

    logic               dim_reg;
    logic signed [31:0] ref_reg [6];
    bte_in_t            item_reg;
    logic               d3_reg;
    bte_state_t         state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    logic signed [31:0] sum_reg [3];
    logic               sat_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;
    logic signed [31:0] t1_reg [3];
    logic signed [31:0] t2_reg [3];
    logic signed [31:0] c_reg  [3];
    logic signed [31:0] trel_reg;
    logic               skip_reg;
    bte_out_t           out_reg;
    logic               out_valid_reg;
    logic               psat_d_reg;

    bte_mac_ctl_t       ctl;
    logic signed [31:0] ma, mb;
    logic signed [63:0] acc_w;
    logic signed [35:0] acc;
    logic               psat, mac_en;
    logic               last_step;
    logic               use_ref2;

    bte_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
        .clk(clk), .rst_n(rst_n), .en(mac_en), .ctl(ctl),
        .a(ma), .b(mb), .acc(acc_w), .psat(psat)
    );

    // outside the dot product every accumulated value fits 36 bits
    assign acc = acc_w[35:0];
    // the exact dot product is in the accumulator during step 3
    assign use_ref2 = (acc_w > THR) || (acc_w < -THR);

    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        if (v > MAX36)
            return 32'sh7fffffff;
        else if (v < MIN36)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic ovf36(input logic signed [35:0] v);
        return (v > MAX36) || (v < MIN36);
    endfunction

    // Step schedule, 3-D: 0-2 dot, 3-8 t1, 9-14 t2, 15-23 c, 24-26 scale.
    // 2-D: 0-1 cx, 2-3 cy, 4-5 scale. One more step folds in the last product.
    logic signed [31:0] tx2d;
    logic               tx2d_sat;
    always_comb
    begin
        tx2d_sat = (item_reg.normal_y == 32'sh80000000);
        tx2d     = tx2d_sat ? 32'sh7fffffff : -item_reg.normal_y;
    end

    logic signed [31:0] scale;
    assign scale = (bte_cmd_t'(item_reg.command) == CMD_RATE) ? trel_reg : item_reg.history_value;

    always_comb
    begin
        ctl       = '0;
        ma        = '0;
        mb        = '0;
        last_step = 1'b0;
        if (d3_reg)
        begin
            unique case (step_reg)
                5'd0:  begin ma = ref_reg[0]; mb = item_reg.normal_x; ctl.start = 1'b1; ctl.raw = 1'b1; end
                5'd1:  begin ma = ref_reg[1]; mb = item_reg.normal_y; ctl.raw = 1'b1; end
                5'd2:  begin ma = ref_reg[2]; mb = item_reg.normal_z; ctl.raw = 1'b1; end
                5'd3:  begin ma = use_ref2 ? ref_reg[4] : ref_reg[1]; mb = item_reg.normal_z; ctl.start = 1'b1; end
                5'd4:  begin ma = rz_reg; mb = item_reg.normal_y; ctl.negate = 1'b1; end
                5'd5:  begin ma = rz_reg; mb = item_reg.normal_x; ctl.start = 1'b1; end
                5'd6:  begin ma = rx_reg; mb = item_reg.normal_z; ctl.negate = 1'b1; end
                5'd7:  begin ma = rx_reg; mb = item_reg.normal_y; ctl.start = 1'b1; end
                5'd8:  begin ma = ry_reg; mb = item_reg.normal_x; ctl.negate = 1'b1; end
                5'd9:  begin ma = item_reg.normal_y; mb = sat36(acc); ctl.start = 1'b1; end
                5'd10: begin ma = item_reg.normal_z; mb = t1_reg[1]; ctl.negate = 1'b1; end
                5'd11: begin ma = item_reg.normal_z; mb = t1_reg[0]; ctl.start = 1'b1; end
                5'd12: begin ma = item_reg.normal_x; mb = t1_reg[2]; ctl.negate = 1'b1; end
                5'd13: begin ma = item_reg.normal_x; mb = t1_reg[1]; ctl.start = 1'b1; end
                5'd14: begin ma = item_reg.normal_y; mb = t1_reg[0]; ctl.negate = 1'b1; end
                5'd15: begin ma = item_reg.amp_tangent1; mb = t1_reg[0]; ctl.start = 1'b1; end
                5'd16: begin ma = item_reg.amp_tangent2; mb = t2_reg[0]; end
                5'd17: begin ma = item_reg.amp_normal; mb = item_reg.normal_x; end
                5'd18: begin ma = item_reg.amp_tangent1; mb = t1_reg[1]; ctl.start = 1'b1; end
                5'd19: begin ma = item_reg.amp_tangent2; mb = t2_reg[1]; end
                5'd20: begin ma = item_reg.amp_normal; mb = item_reg.normal_y; end
                5'd21: begin ma = item_reg.amp_tangent1; mb = t1_reg[2]; ctl.start = 1'b1; end
                5'd22: begin ma = item_reg.amp_tangent2; mb = t2_reg[2]; end
                5'd23: begin ma = item_reg.amp_normal; mb = item_reg.normal_z; end
                5'd24: begin ma = scale; mb = c_reg[0]; ctl.start = 1'b1; end
                5'd25: begin ma = scale; mb = c_reg[1]; ctl.start = 1'b1; end
                5'd26: begin ma = scale; mb = c_reg[2]; ctl.start = 1'b1; end
                default: last_step = 1'b1;
            endcase
        end
        else
        begin
            unique case (step_reg)
                5'd0: begin ma = item_reg.amp_tangent1; mb = tx2d; ctl.start = 1'b1; end
                5'd1: begin ma = item_reg.amp_normal; mb = item_reg.normal_x; end
                5'd2: begin ma = item_reg.amp_tangent1; mb = item_reg.normal_x; ctl.start = 1'b1; end
                5'd3: begin ma = item_reg.amp_normal; mb = item_reg.normal_y; end
                5'd4: begin ma = scale; mb = c_reg[0]; ctl.start = 1'b1; end
                5'd5: begin ma = scale; mb = c_reg[1]; ctl.start = 1'b1; end
                default: last_step = 1'b1;
            endcase
        end
    end

    // accumulator value is ready in the cycle after the step that finishes it
    logic [4:0] done_step;
    logic       run_d_reg;
    logic [4:0] prev_reg;
    assign done_step = prev_reg;
    assign mac_en    = (state_reg == ST_RUN);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && !in_stall)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            ST_RUN:
                if (skip_reg || last_step)
                    state_next = ST_OUT;
                else
                    step_next = step_reg + 5'd1;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic signed [32:0] trel_full;
    logic               trel_ovf;
    assign trel_full = 33'(item_reg.time_now) - 33'(item_reg.start_time);
    assign trel_ovf  = (trel_full > 33'sd2147483647) || (trel_full < -33'sd2147483648);

    // scaling products only count when the term is actually scaled
    logic scale_step;
    logic scale_used;
    always_comb
    begin
        scale_step = d3_reg ? (step_reg >= 5'd24) : (step_reg >= 5'd4);
        scale_used = (bte_cmd_t'(item_reg.command) != CMD_INITIAL) &&
                     !((bte_cmd_t'(item_reg.command) == CMD_RATE) && (trel_reg <= 32'sd0));
    end

    // index of the current result within the scaled add (3-way in 3-D, 2-way in 2-D)
    logic [1:0] add_idx;
    logic       is_add;
    always_comb
    begin
        is_add  = 1'b0;
        add_idx = '0;
        if (d3_reg && done_step >= 5'd24 && done_step <= 5'd26)
        begin
            is_add  = 1'b1;
            add_idx = 2'(done_step - 5'd24);
        end
        else if (!d3_reg && (done_step == 5'd4 || done_step == 5'd5))
        begin
            is_add  = 1'b1;
            add_idx = 2'(done_step - 5'd4);
        end
    end

    logic signed [31:0] addend;
    logic               addend_sat;
    logic signed [32:0] sum_wide;
    logic               use_add;
    always_comb
    begin
        addend     = (bte_cmd_t'(item_reg.command) == CMD_INITIAL) ? c_reg[add_idx] : sat36(acc);
        addend_sat = (bte_cmd_t'(item_reg.command) == CMD_INITIAL) ? 1'b0 : ovf36(acc);
        sum_wide   = 33'(sum_reg[add_idx]) + 33'(addend);
        use_add    = is_add && run_d_reg &&
                     !((bte_cmd_t'(item_reg.command) == CMD_RATE) && (trel_reg <= 32'sd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            prev_reg      <= '0;
            run_d_reg     <= 1'b0;
            dim_reg       <= 1'b1;
            ref_reg[0]    <= 32'sd0;
            ref_reg[1]    <= 32'sd0;
            ref_reg[2]    <= 32'sd65536;
            ref_reg[3]    <= 32'sd0;
            ref_reg[4]    <= 32'sd65536;
            ref_reg[5]    <= 32'sd0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            skip_reg      <= 1'b0;
            d3_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            prev_reg  <= step_reg;
            run_d_reg <= mac_en && !skip_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DIM:    dim_reg    <= cfg_data[0];
                    REG_REF1_X: ref_reg[0] <= cfg_data;
                    REG_REF1_Y: ref_reg[1] <= cfg_data;
                    REG_REF1_Z: ref_reg[2] <= cfg_data;
                    REG_REF2_X: ref_reg[3] <= cfg_data;
                    REG_REF2_Y: ref_reg[4] <= cfg_data;
                    REG_REF2_Z: ref_reg[5] <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE && in_valid && !in_stall)
            begin
                d3_reg   <= dim_reg;
                skip_reg <= (bte_cmd_t'(in_data.command) == CMD_NONE);
            end
            if (state_reg == ST_RUN && step_reg == 5'd0 &&
                bte_cmd_t'(item_reg.command) == CMD_RATE && trel_ovf)
                sat_reg <= 1'b1;
            if (run_d_reg && !d3_reg && done_step == 5'd0 && tx2d_sat)
                sat_reg <= 1'b1;
            if (run_d_reg && psat_d_reg)
                sat_reg <= 1'b1;
            if (run_d_reg && sat_stage(done_step))
                sat_reg <= 1'b1;
            if (use_add)
            begin
                sum_reg[add_idx] <= sat36(36'(sum_wide));
                if (addend_sat || ovf36(36'(sum_wide)))
                    sat_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && item_reg.last_term)
            begin
                out_valid_reg <= 1'b1;
                sum_reg[0]    <= '0;
                sum_reg[1]    <= '0;
                sum_reg[2]    <= '0;
                sat_reg       <= 1'b0;
            end
        end
    end

    // product saturation counts except in the dot product and unused scaling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            psat_d_reg <= 1'b0;
        else
            psat_d_reg <= psat && mac_en && !skip_reg && !(d3_reg && step_reg <= 5'd2) &&
                          !(scale_step && !scale_used);
    end

    // stages whose accumulated sum is saturated into a 32-bit value
    function automatic logic sat_stage(input logic [4:0] s);
        if (d3_reg)
            return ((s == 5'd4) || (s == 5'd6) || (s == 5'd8) || (s == 5'd10) ||
                    (s == 5'd12) || (s == 5'd14) || (s == 5'd17) || (s == 5'd20) ||
                    (s == 5'd23)) && ovf36(acc);
        return ((s == 5'd1) || (s == 5'd3)) && ovf36(acc);
    endfunction

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !in_stall)
            item_reg <= in_data;
        if (state_reg == ST_RUN && step_reg == 5'd0)
            trel_reg <= (trel_full > 33'sd2147483647) ? 32'sh7fffffff :
                        (trel_full < -33'sd2147483648) ? 32'sh80000000 : trel_full[31:0];
        if (run_d_reg)
        begin
            if (d3_reg)
            begin
                unique case (done_step)
                    5'd2:
                        if (use_ref2)
                        begin
                            rx_reg <= ref_reg[3]; ry_reg <= ref_reg[4]; rz_reg <= ref_reg[5];
                        end
                        else
                        begin
                            rx_reg <= ref_reg[0]; ry_reg <= ref_reg[1]; rz_reg <= ref_reg[2];
                        end
                    5'd4:  t1_reg[0] <= sat36(acc);
                    5'd6:  t1_reg[1] <= sat36(acc);
                    5'd8:  t1_reg[2] <= sat36(acc);
                    5'd10: t2_reg[0] <= sat36(acc);
                    5'd12: t2_reg[1] <= sat36(acc);
                    5'd14: t2_reg[2] <= sat36(acc);
                    5'd17: c_reg[0]  <= sat36(acc);
                    5'd20: c_reg[1]  <= sat36(acc);
                    5'd23: c_reg[2]  <= sat36(acc);
                    default: ;
                endcase
            end
            else
            begin
                if (done_step == 5'd1)
                    c_reg[0] <= sat36(acc);
                if (done_step == 5'd3)
                    c_reg[1] <= sat36(acc);
            end
        end
        if (state_reg == ST_OUT && item_reg.last_term && !(out_valid_reg && out_stall))
        begin
            out_reg.force_x   <= sum_reg[0];
            out_reg.force_y   <= sum_reg[1];
            out_reg.force_z   <= d3_reg ? sum_reg[2] : 32'sd0;
            out_reg.saturated <= sat_reg;
        end
    end
endmodule
